[sv/gbgl_pkg.sv]
// ----------------------------------------------------------------------------
// gbgl_pkg: shared types and constants for the GB2312/ASCII glyph locator
// Byte classes, register indexes, item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package gbgl_pkg;

  // field widths
  localparam int unsigned AddrW = 24;
  localparam int unsigned OffsW = 16;
  localparam int unsigned ColW  = 8;
  localparam int unsigned PageW = 3;
  localparam int unsigned IdxW  = 17;  // glyph index before scaling by 32

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_ASCII_FONT_BASE    = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HANZI_GLYPH_OFFSET = 1'b1;

  // configuration reset values
  localparam logic [AddrW-1:0] ASCII_BASE_RST   = 24'h03CF80;
  localparam logic [OffsW-1:0] HANZI_OFFSET_RST = 16'd846;

  // byte classes
  localparam logic [7:0] BYTE_END   = 8'h00;
  localparam logic [7:0] LEAD_LOW   = 8'hB0;
  localparam logic [7:0] LEAD_HIGH  = 8'hF7;
  localparam logic [7:0] TRAIL_LOW  = 8'hA1;
  localparam logic [7:0] ASCII_LOW  = 8'h20;
  localparam logic [7:0] ASCII_HIGH = 8'h7E;

  // glyphs per GB2312 row, column steps
  localparam logic [6:0]      ROW_SIZE    = 7'd94;
  localparam logic [ColW-1:0] WIDE_STEP   = 8'd16;
  localparam logic [ColW-1:0] NARROW_STEP = 8'd8;

  typedef struct packed {
    logic             cmd;
    logic [7:0]       byte_value;
    logic [ColW-1:0]  start_column;
    logic [PageW-1:0] start_page;
  } item_t;

  typedef struct packed {
    logic [7:0]       held_lead;
    logic             lead_pending;
    logic [ColW-1:0]  current_column;
    logic [PageW-1:0] current_page;
    logic             line_active;
  } line_state_t;

  typedef struct packed {
    logic [AddrW-1:0] font_address;
    logic             glyph_wide;
    logic [ColW-1:0]  glyph_column;
    logic [PageW-1:0] glyph_page;
  } result_t;

  typedef struct packed {
    logic [AddrW-1:0] ascii_font_base;
    logic [OffsW-1:0] hanzi_glyph_offset;
  } cfg_t;

endpackage

`default_nettype wire

[sv/gbgl_if.sv]
// ----------------------------------------------------------------------------
// gbgl_if: valid/ready channels of the glyph locator
// Text item channel and glyph request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbgl_in_if
  import gbgl_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [7:0]       byte_value;
  logic [ColW-1:0]  start_column;
  logic [PageW-1:0] start_page;

  modport source (output valid, cmd, byte_value, start_column, start_page,
                  input ready);
  modport sink   (input valid, cmd, byte_value, start_column, start_page,
                  output ready);
endinterface

interface gbgl_out_if
  import gbgl_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] font_address;
  logic             glyph_wide;
  logic [ColW-1:0]  glyph_column;
  logic [PageW-1:0] glyph_page;

  modport source (output valid, font_address, glyph_wide, glyph_column, glyph_page,
                  input ready);
  modport sink   (input valid, font_address, glyph_wide, glyph_column, glyph_page,
                  output ready);
endinterface

`default_nettype wire

[sv/gbgl_calc.sv]
// ----------------------------------------------------------------------------
// gbgl_calc: per-byte decode and font address calculation
// Classifies one item against the line state, forms the glyph request and
// the next line state.
// ----------------------------------------------------------------------------
`default_nettype none

module gbgl_calc
  import gbgl_pkg::*;
(
  input  item_t       item,
  input  line_state_t st,
  input  cfg_t        cfg,
  output line_state_t st_next,
  output logic        res_valid,
  output result_t     res
);

  logic [6:0]      row;        // lead - 0xB0
  logic [12:0]     row_base;   // row * 94
  logic [6:0]      trail_ofs;  // trail - 0xA1
  logic [IdxW-1:0] glyph_idx;
  logic [6:0]      ascii_ofs;  // c - 0x20
  logic [AddrW-1:0] wide_addr;
  logic [AddrW-1:0] narrow_addr;
  logic            is_lead;
  logic            is_ascii;
  logic            is_trail;

  // address arithmetic
  always_comb begin
    row         = 7'(st.held_lead - LEAD_LOW);
    row_base    = 13'(row * ROW_SIZE);
    trail_ofs   = 7'(item.byte_value - TRAIL_LOW);
    glyph_idx   = IdxW'(row_base) + IdxW'(trail_ofs) + IdxW'(cfg.hanzi_glyph_offset);
    wide_addr   = {2'b00, glyph_idx, 5'b00000};
    ascii_ofs   = 7'(item.byte_value - ASCII_LOW);
    narrow_addr = cfg.ascii_font_base + {13'd0, ascii_ofs, 4'b0000};
  end

  // byte classes
  assign is_lead  = (item.byte_value >= LEAD_LOW) && (item.byte_value <= LEAD_HIGH);
  assign is_ascii = (item.byte_value >= ASCII_LOW) && (item.byte_value <= ASCII_HIGH);
  assign is_trail = (item.byte_value >= TRAIL_LOW);

  // decode and state update
  always_comb begin
    st_next          = st;
    res_valid        = 1'b0;
    res.font_address = narrow_addr;
    res.glyph_wide   = 1'b0;
    res.glyph_column = st.current_column;
    res.glyph_page   = st.current_page;

    if (item.cmd == CMD_START) begin
      st_next.current_column = item.start_column;
      st_next.current_page   = item.start_page;
      st_next.line_active    = 1'b1;
      st_next.lead_pending   = 1'b0;
      st_next.held_lead      = '0;
    end else if (st.line_active) begin
      if (st.lead_pending) begin
        st_next.lead_pending = 1'b0;
        st_next.held_lead    = '0;
      end
      if (st.lead_pending && is_trail) begin
        // two-byte glyph completes
        res_valid        = 1'b1;
        res.glyph_wide   = 1'b1;
        res.font_address = wide_addr;
      end else if (item.byte_value == BYTE_END) begin
        st_next.line_active = 1'b0;
      end else if (is_lead) begin
        st_next.held_lead    = item.byte_value;
        st_next.lead_pending = 1'b1;
      end else if (is_ascii) begin
        res_valid = 1'b1;
      end
    end

    // column advances past each emitted glyph, wrapping
    if (res_valid) begin
      st_next.current_column = st.current_column + (res.glyph_wide ? WIDE_STEP : NARROW_STEP);
    end
  end

endmodule

`default_nettype wire

[sv/gb2312_ascii_glyph_locator.sv]
// ----------------------------------------------------------------------------
// gb2312_ascii_glyph_locator: GB2312/ASCII text to font ROM glyph requests
// Input register, one pass of decode logic, result register.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  text_in    in   valid/ready    cmd, byte_value, start_column, start_page
//  glyph_out  out  valid/ready    font_address, glyph_wide, glyph_column, glyph_page
//  cfg        in   cfg_wr_en      cfg_index, cfg_data
//
// An item is held in the input register and its request is then captured in the
// result register; one item per cycle while the result register is not stalled.
// Line state updates as the item leaves the input register.
// A stalled result register holds the input register; text_in.ready then drops.
// Synchronous reset clears the line state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2312_ascii_glyph_locator
  import gbgl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  gbgl_in_if.sink                 text_in,
  gbgl_out_if.source              glyph_out,
  input  wire logic               cfg_wr_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [AddrW-1:0]   cfg_data
);

  cfg_t        cfg;
  item_t       item_r;
  logic        item_valid;
  line_state_t st;
  line_state_t st_next;
  logic        res_valid;
  result_t     res;
  result_t     out_r;
  logic        out_valid;
  logic        advance;

  // pipeline control
  assign advance       = !out_valid || glyph_out.ready;
  assign text_in.ready = !item_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ascii_font_base    <= ASCII_BASE_RST;
      cfg.hanzi_glyph_offset <= HANZI_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ASCII_FONT_BASE:    cfg.ascii_font_base    <= cfg_data;
        REG_HANZI_GLYPH_OFFSET: cfg.hanzi_glyph_offset <= cfg_data[OffsW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text_in.ready) begin
      item_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      item_r.cmd          <= text_in.cmd;
      item_r.byte_value   <= text_in.byte_value;
      item_r.start_column <= text_in.start_column;
      item_r.start_page   <= text_in.start_page;
    end
  end

  // decode
  gbgl_calc u_calc (
    .item      (item_r),
    .st        (st),
    .cfg       (cfg),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (item_valid && advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && res_valid) begin
      out_r <= res;
    end
  end

  assign glyph_out.valid        = out_valid;
  assign glyph_out.font_address = out_r.font_address;
  assign glyph_out.glyph_wide   = out_r.glyph_wide;
  assign glyph_out.glyph_column = out_r.glyph_column;
  assign glyph_out.glyph_page   = out_r.glyph_page;

endmodule

`default_nettype wire
